// File: rtl/core/aasc_pkg.sv
// Shared constants and types for the absolute angle to step counter.
`timescale 1ns / 1ps

package aasc_pkg;

  localparam logic [1:0] ACT_SAMPLE  = 2'd0;
  localparam logic [1:0] ACT_FAIL    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [8:0] ANGLE_FULL   = 9'd360;
  localparam logic signed [9:0] HALF_TURN_S = 10'sd180;
  localparam logic signed [9:0] FULL_TURN_S = 10'sd360;

  localparam logic [8:0] DPS_RESET = 9'd18;
  localparam logic [8:0] DPS_MIN   = 9'd1;
  localparam logic [8:0] DPS_MAX   = 9'd360;

  localparam int unsigned DIV_ITERS = 10;
  localparam logic [3:0]  DIV_LAST  = 4'(DIV_ITERS - 1);

  localparam logic signed [63:0] COUNT_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] COUNT_MIN = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic               done;
    logic signed [10:0] quot;
    logic signed [9:0]  rem;
  } aasc_div_res_t;

endpackage

// File: rtl/core/aasc_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module aasc_div
  import aasc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [10:0] dividend_i,
  input  logic [8:0]         divisor_i,
  output aasc_div_res_t      res_o
);

  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic [3:0] cnt_q, cnt_d;
  logic       neg_q, neg_d;
  logic [9:0] mag_q, mag_d;
  logic [8:0] rem_q, rem_d;
  logic [8:0] dvs_q, dvs_d;

  logic [9:0]  trial;
  logic [9:0]  trial_sub;
  logic        trial_ge;
  logic [10:0] quot_ext;
  logic [9:0]  rem_ext;

  assign trial     = {rem_q, mag_q[9]};
  assign trial_ge  = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = dividend_i[10];
      mag_d  = dividend_i[10] ? 10'(-dividend_i) : dividend_i[9:0];
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = trial_ge ? trial_sub[8:0] : trial[8:0];
      mag_d = {mag_q[8:0], trial_ge};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == DIV_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quot_ext = {1'b0, mag_q};
  assign rem_ext  = {1'b0, rem_q};

  assign res_o.done = done_q;
  assign res_o.quot = neg_q ? $signed(11'(-quot_ext)) : $signed(quot_ext);
  assign res_o.rem  = neg_q ? $signed(10'(-rem_ext)) : $signed(rem_ext);

  // remainder stays below the divisor while iterating
  a_rem_below_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i |-> rem_q < dvs_q)
    else $error("divider partial remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a finishing iteration");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= DIV_LAST)
    else $error("divider iteration count out of range");

endmodule

// File: rtl/core/absolute_angle_to_step_counter_core.sv
// Each word passes PREP, then DIV only for a sample whose angle changed, then DONE, where its result is registered.
// A new word is taken only in IDLE, once the previous word has been committed to the result register.
// The result register frees the input side: the next word is taken while a result waits.
// Reset: asynchronous active low; count, residual and samples clear, deg_per_step returns to 18.
// Top level: angle unwrap, residual divide and saturating step count.
`timescale 1ns / 1ps

module absolute_angle_to_step_counter_core
  import aasc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [8:0]         position_deg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [8:0]  angle_delta_o,
  output logic signed [8:0]  step_delta_o,
  output logic signed [63:0] step_count_o,
  output logic [8:0]         latest_angle_o,
  output logic               latest_valid_o,
  input  logic               cfg_we_i,
  input  logic [8:0]         cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  logic [8:0]         dps_q;
  logic [8:0]         prev_q;
  logic               have_prev_q;
  logic signed [9:0]  residual_q;
  logic signed [63:0] total_q;
  logic [8:0]         last_q;
  logic               seen_q;

  logic [1:0]        act_q;
  logic [8:0]        pos_q;
  logic              changed_q;
  logic signed [8:0] delta_q;
  logic signed [8:0] step_q;
  logic signed [9:0] rem_q;

  logic               out_valid_q;
  logic signed [8:0]  out_adelta_q;
  logic signed [8:0]  out_sdelta_q;
  logic signed [63:0] out_count_q;
  logic [8:0]         out_latest_q;
  logic               out_lvalid_q;

  logic              accept;
  logic              commit;
  logic [8:0]        pos_red;
  logic [8:0]        div_clamp;
  logic              changed;
  logic signed [9:0] diff;
  logic signed [9:0] wrapped;
  logic signed [8:0] delta;
  logic signed [10:0] sum;
  logic              div_start;
  aasc_div_res_t     div_res;
  logic signed [64:0] count_sum;
  logic signed [63:0] count_sat;
  logic [9:0]        res_mag;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign pos_red = (position_deg_i >= ANGLE_FULL) ? position_deg_i - ANGLE_FULL
                                                   : position_deg_i;

  always_comb begin
    if (dps_q == '0) begin
      div_clamp = DPS_MIN;
    end else if (dps_q > DPS_MAX) begin
      div_clamp = DPS_MAX;
    end else begin
      div_clamp = dps_q;
    end
  end

  assign changed = (act_q == ACT_SAMPLE) && (!have_prev_q || pos_q != prev_q);
  assign diff    = $signed({1'b0, pos_q}) - $signed({1'b0, prev_q});

  always_comb begin
    if (diff > HALF_TURN_S) begin
      wrapped = diff - FULL_TURN_S;
    end else if (diff < -HALF_TURN_S) begin
      wrapped = diff + FULL_TURN_S;
    end else begin
      wrapped = diff;
    end
  end

  assign delta     = have_prev_q ? wrapped[8:0] : '0;
  assign sum       = 11'(residual_q) + 11'(delta);
  assign div_start = (state_q == ST_PREP) && changed;

  aasc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum),
    .divisor_i  (div_clamp),
    .res_o      (div_res)
  );

  assign count_sum = 65'(total_q) + 65'(step_q);

  always_comb begin
    if (count_sum[64] != count_sum[63]) begin
      count_sat = count_sum[64] ? COUNT_MIN : COUNT_MAX;
    end else begin
      count_sat = count_sum[63:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = changed ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dps_q       <= DPS_RESET;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      residual_q  <= '0;
      total_q     <= '0;
      last_q      <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_ready_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        unique case (act_q)
          ACT_RESTART: begin
            prev_q      <= '0;
            have_prev_q <= 1'b0;
            residual_q  <= '0;
            total_q     <= '0;
            last_q      <= '0;
            seen_q      <= 1'b0;
          end
          ACT_SAMPLE: begin
            last_q <= pos_q;
            seen_q <= 1'b1;
            if (changed_q) begin
              prev_q      <= pos_q;
              have_prev_q <= 1'b1;
              residual_q  <= rem_q;
              total_q     <= count_sat;
            end
          end
          default: ;
        endcase
      end
      if (cfg_we_i) begin
        dps_q      <= cfg_wdata_i;
        residual_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      pos_q <= pos_red;
    end
    if (state_q == ST_PREP) begin
      changed_q <= changed;
      delta_q   <= delta;
      step_q    <= '0;
    end
    if ((state_q == ST_DIV) && div_res.done) begin
      step_q <= div_res.quot[8:0];
      rem_q  <= div_res.rem;
    end
    if (commit) begin
      unique case (act_q)
        ACT_RESTART: begin
          out_adelta_q <= '0;
          out_sdelta_q <= '0;
          out_count_q  <= '0;
          out_latest_q <= '0;
          out_lvalid_q <= 1'b0;
        end
        ACT_SAMPLE: begin
          out_adelta_q <= changed_q ? delta_q : '0;
          out_sdelta_q <= changed_q ? step_q : '0;
          out_count_q  <= changed_q ? count_sat : total_q;
          out_latest_q <= pos_q;
          out_lvalid_q <= 1'b1;
        end
        default: begin
          out_adelta_q <= '0;
          out_sdelta_q <= '0;
          out_count_q  <= total_q;
          out_latest_q <= last_q;
          out_lvalid_q <= seen_q;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign angle_delta_o  = out_adelta_q;
  assign step_delta_o   = out_sdelta_q;
  assign step_count_o   = out_count_q;
  assign latest_angle_o = out_latest_q;
  assign latest_valid_o = out_lvalid_q;

  assign res_mag = residual_q[9] ? 10'(-residual_q) : residual_q;

  a_residual_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_mag < {1'b0, div_clamp})
    else $error("residual not below the step size");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_prev_implies_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_prev_q |-> seen_q)
    else $error("previous angle held without a sample seen");

  a_unseen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> last_q == '0)
    else $error("latest angle non-zero with no sample seen");

endmodule
